@@ hdl/rcpc_pkg.sv @@
// Shared types and constants of the RC pulse capture and range map block.
// No dependencies; every other file refers to it by scoped names.
package rcpc_pkg;

  // Field widths of the stream items and registers.
  localparam int CHAN_W  = 4;
  localparam int STAMP_W = 32;
  localparam int WIDTH_W = 16;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 2 * WIDTH_W;
  localparam int RAW_W   = PROD_W + 3;

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam logic [2:0] REG_ENABLE  = 3'd0;
  localparam logic [2:0] REG_IN_MIN  = 3'd1;
  localparam logic [2:0] REG_IN_MAX  = 3'd2;
  localparam logic [2:0] REG_OUT_MIN = 3'd3;
  localparam logic [2:0] REG_OUT_MAX = 3'd4;

  // Register values after reset.
  localparam logic [WIDTH_W-1:0]      IN_MIN_RST  = 16'd1000;
  localparam logic [WIDTH_W-1:0]      IN_MAX_RST  = 16'd2000;
  localparam logic signed [VAL_W-1:0] OUT_MIN_RST = 16'sd0;
  localparam logic signed [VAL_W-1:0] OUT_MAX_RST = 16'sd100;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_SUM,
    ST_OUT
  } state_t;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

@@ hdl/rcpc_mul.sv @@
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
// Depends on rcpc_pkg for widths and the status struct.
module rcpc_mul (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [rcpc_pkg::WIDTH_W-1:0]     mcand,
  input  logic [rcpc_pkg::WIDTH_W-1:0]     mplier,
  output rcpc_pkg::unit_stat_t             stat,
  output logic [rcpc_pkg::PROD_W-1:0]      product
);

  localparam int W     = rcpc_pkg::WIDTH_W;
  localparam int CNT_W = $clog2(W);

  logic               busy;
  logic               done;
  logic [CNT_W-1:0]   cnt;
  logic [W-1:0]       mc;
  logic [W-1:0]       hi;
  logic [W-1:0]       lo;
  logic [W:0]         sum;

  // Add the multiplicand when the low bit of the multiplier is set.
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mc} : {(W+1){1'b0}});

  // Control: a step counter that runs once per start.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the partial product right one bit per step.
  always_ff @(posedge clk) begin
    if (start) begin
      mc <= mcand;
      hi <= '0;
      lo <= mplier;
    end else if (busy) begin
      hi <= sum[W:1];
      lo <= {sum[0], lo[W-1:1]};
    end
  end

  assign stat    = '{busy: busy, done: done};
  assign product = {hi, lo};

endmodule

@@ hdl/rcpc_div.sv @@
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on rcpc_pkg for widths and the status struct.
module rcpc_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [rcpc_pkg::PROD_W-1:0]      dividend,
  input  logic [rcpc_pkg::WIDTH_W-1:0]     divisor,
  output rcpc_pkg::unit_stat_t             stat,
  output logic [rcpc_pkg::PROD_W-1:0]      quotient
);

  localparam int NW    = rcpc_pkg::PROD_W;
  localparam int DW    = rcpc_pkg::WIDTH_W;
  localparam int CNT_W = $clog2(NW);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    dv;
  logic [DW-1:0]    rem;
  logic [NW-1:0]    q;
  logic [DW:0]      shifted;
  logic [DW:0]      diff;
  logic             ge;

  // One trial subtraction per step.
  assign shifted = {rem, q[NW-1]};
  assign ge      = shifted >= {1'b0, dv};
  assign diff    = shifted - {1'b0, dv};

  // Control: a step counter that runs once per start.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend bits shift out at the top, quotient bits in at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      dv  <= divisor;
      rem <= '0;
      q   <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      q   <= {q[NW-2:0], ge};
    end
  end

  assign stat     = '{busy: busy, done: done};
  assign quotient = q;

endmodule

@@ hdl/rc_pulse_capture_and_range_map.sv @@
// Top level of the RC pulse capture and range map block.
// Depends on rcpc_pkg, rcpc_mul and rcpc_div.
//
// Each input beat on the s_ channel is one pin edge: channel, level and a
// microsecond timestamp. A rising edge on an enabled channel stores the stamp
// and is finished in the cycle it is accepted. A falling edge on an enabled
// channel measures the high time (saturated to 65535), maps it linearly from
// in_min..in_max to out_min..out_max and sends one beat on the m_ channel with
// the clamped value, the held last in-range value and an in-range flag.
// Edges on disabled or nonexistent channels are dropped without a result.
// A falling edge passes through the sequencer states in order: operands are
// formed, the serial multiplier and then the serial divider run, and the
// quotient plus out_min is registered and clamped into the output register.
// s_tready is high only while the sequencer is idle, so no edge is taken while
// a falling edge is in work; other edges are taken every cycle while it is
// idle. The result waits in an output register, so a new edge is accepted
// meanwhile; a stalled receiver holds the next falling edge in its last step.
// Reset clears all stored stamps and held values to zero and loads the
// register defaults (ranges 1000..2000 to 0..100, all channels disabled).
// Registers sit on an APB-style port at byte addresses 4 * index.
module rc_pulse_capture_and_range_map #(
  parameter int CHANNELS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  // Edge beats. s_tdata: chan [3:0], stamp [35:4], zero fill [39:36].
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [39:0]           s_tdata,
  // s_tuser: level [0] (1 rising edge, 0 falling edge).
  input  logic                  s_tuser,
  // Result beats. m_tdata: out_chan [3:0], pulse_width [19:4],
  // mapped_value [35:20], held_value [51:36], zero fill [55:52].
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [55:0]           m_tdata,
  // m_tuser: in_range [0].
  output logic                  m_tuser,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int CHAN_W  = rcpc_pkg::CHAN_W;
  localparam int STAMP_W = rcpc_pkg::STAMP_W;
  localparam int WIDTH_W = rcpc_pkg::WIDTH_W;
  localparam int VAL_W   = rcpc_pkg::VAL_W;
  localparam int PROD_W  = rcpc_pkg::PROD_W;
  localparam int RAW_W   = rcpc_pkg::RAW_W;
  localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers.
  logic [CHANNELS-1:0]        channel_enable;
  logic [WIDTH_W-1:0]         in_min;
  logic [WIDTH_W-1:0]         in_max;
  logic signed [VAL_W-1:0]    out_min;
  logic signed [VAL_W-1:0]    out_max;

  // Per-channel state.
  logic [STAMP_W-1:0]         rise_time [CHANNELS];
  logic signed [VAL_W-1:0]    last_valid [CHANNELS];

  // Sequencer and working registers.
  rcpc_pkg::state_t           state;
  rcpc_pkg::state_t           state_next;
  logic [CHAN_W-1:0]          cur_chan;
  logic [IDX_W-1:0]           cur_idx;
  logic [WIDTH_W-1:0]         width;
  logic                       neg;
  logic                       span_zero;
  logic [WIDTH_W-1:0]         span_mag;
  logic signed [RAW_W-1:0]    raw;

  // Output register.
  logic                       out_valid;
  logic [CHAN_W-1:0]          out_chan;
  logic [WIDTH_W-1:0]         out_width;
  logic signed [VAL_W-1:0]    out_mapped;
  logic signed [VAL_W-1:0]    out_held;
  logic                       out_in_range;

  // Input beat fields.
  logic [CHAN_W-1:0]          s_chan;
  logic [STAMP_W-1:0]         s_stamp;
  logic [IDX_W-1:0]           s_idx;
  logic [15:0]                enable_ext;
  logic                       s_enabled;
  logic                       in_fire;
  logic [STAMP_W-1:0]         diff;

  // Operand forming.
  logic signed [WIDTH_W:0]    a_val;
  logic signed [WIDTH_W:0]    b_val;
  logic signed [WIDTH_W:0]    s_val;
  logic [WIDTH_W:0]           a_abs;
  logic [WIDTH_W:0]           b_abs;
  logic [WIDTH_W:0]           s_abs;

  // Serial units.
  logic                       mul_start;
  logic                       div_start;
  rcpc_pkg::unit_stat_t       mul_stat;
  rcpc_pkg::unit_stat_t       div_stat;
  logic [PROD_W-1:0]          product;
  logic [PROD_W-1:0]          quotient;

  // Final add and clamp.
  logic [RAW_W-1:0]           q_mag;
  logic signed [RAW_W-1:0]    q_signed;
  logic signed [RAW_W-1:0]    lo_bound;
  logic signed [RAW_W-1:0]    hi_bound;
  logic                       below;
  logic                       above;
  logic                       ok;
  logic                       out_free;
  logic                       out_load;
  logic signed [VAL_W-1:0]    clamped;
  logic signed [VAL_W-1:0]    held;

  logic                       cfg_write;
  logic [2:0]                 cfg_index;

  // Input decode and channel enable check.
  assign s_chan     = s_tdata[3:0];
  assign s_stamp    = s_tdata[35:4];
  assign s_idx      = s_chan[IDX_W-1:0];
  assign enable_ext = 16'(channel_enable);
  assign s_enabled  = ({1'b0, s_chan} < 5'(CHANNELS)) && enable_ext[s_chan];
  assign in_fire    = s_tvalid && s_tready;
  assign diff       = s_stamp - rise_time[s_idx];
  assign cur_idx    = cur_chan[IDX_W-1:0];

  // Signed operands: width offset, output span and input span.
  assign a_val = $signed({1'b0, width}) - $signed({1'b0, in_min});
  assign b_val = (VAL_W+1)'(out_max) - (VAL_W+1)'(out_min);
  assign s_val = $signed({1'b0, in_max}) - $signed({1'b0, in_min});
  assign a_abs = a_val[WIDTH_W] ? -a_val : a_val;
  assign b_abs = b_val[WIDTH_W] ? -b_val : b_val;
  assign s_abs = s_val[WIDTH_W] ? -s_val : s_val;

  // Signed quotient plus out_min, then bounds check.
  assign q_mag    = span_zero ? '0 : RAW_W'(quotient);
  assign q_signed = neg ? -$signed(q_mag) : $signed(q_mag);
  assign lo_bound = RAW_W'(out_min);
  assign hi_bound = RAW_W'(out_max);
  assign below    = raw < lo_bound;
  assign above    = raw > hi_bound;
  assign ok       = !below && !above;
  assign clamped  = below ? out_min : (above ? out_max : raw[VAL_W-1:0]);
  assign held     = ok ? raw[VAL_W-1:0] : last_valid[cur_idx];
  assign out_free = !out_valid || m_tready;

  rcpc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (a_abs[WIDTH_W-1:0]),
    .mplier  (b_abs[WIDTH_W-1:0]),
    .stat    (mul_stat),
    .product (product)
  );

  rcpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (span_mag),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rcpc_pkg::ST_IDLE: begin
        if (in_fire && s_enabled && !s_tuser) begin
          state_next = rcpc_pkg::ST_PREP;
        end
      end
      rcpc_pkg::ST_PREP: state_next = rcpc_pkg::ST_MUL;
      rcpc_pkg::ST_MUL: begin
        if (mul_stat.done) begin
          state_next = rcpc_pkg::ST_DIV;
        end
      end
      rcpc_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_next = rcpc_pkg::ST_SUM;
        end
      end
      rcpc_pkg::ST_SUM: state_next = rcpc_pkg::ST_OUT;
      rcpc_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = rcpc_pkg::ST_IDLE;
        end
      end
      default: state_next = rcpc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      rcpc_pkg::ST_IDLE: s_tready  = 1'b1;
      rcpc_pkg::ST_PREP: mul_start = 1'b1;
      rcpc_pkg::ST_MUL:  div_start = mul_stat.done;
      rcpc_pkg::ST_DIV:  ;
      rcpc_pkg::ST_SUM:  ;
      rcpc_pkg::ST_OUT:  out_load  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcpc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers: measured width, operand signs and the sum.
  always_ff @(posedge clk) begin
    if (in_fire && s_enabled && !s_tuser) begin
      cur_chan <= s_chan;
      width    <= (diff[STAMP_W-1:WIDTH_W] != '0) ? '1 : diff[WIDTH_W-1:0];
    end
    if (state == rcpc_pkg::ST_PREP) begin
      neg       <= a_val[WIDTH_W] ^ b_val[WIDTH_W] ^ s_val[WIDTH_W];
      span_zero <= (s_val == '0);
      span_mag  <= s_abs[WIDTH_W-1:0];
    end
    if (state == rcpc_pkg::ST_SUM) begin
      raw <= q_signed + lo_bound;
    end
  end

  // Per-channel stamps and held values.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rise_time[i]  <= '0;
        last_valid[i] <= '0;
      end
    end else begin
      if (in_fire && s_enabled && s_tuser) begin
        rise_time[s_idx] <= s_stamp;
      end
      if (out_load && ok) begin
        last_valid[cur_idx] <= raw[VAL_W-1:0];
      end
    end
  end

  // Output register: loads when the previous result is gone or leaving.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chan     <= cur_chan;
      out_width    <= width;
      out_mapped   <= clamped;
      out_held     <= held;
      out_in_range <= ok;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0, out_held, out_mapped, out_width, out_chan};
  assign m_tuser  = out_in_range;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable <= '0;
      in_min         <= rcpc_pkg::IN_MIN_RST;
      in_max         <= rcpc_pkg::IN_MAX_RST;
      out_min        <= rcpc_pkg::OUT_MIN_RST;
      out_max        <= rcpc_pkg::OUT_MAX_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rcpc_pkg::REG_ENABLE:  channel_enable <= pwdata[CHANNELS-1:0];
        rcpc_pkg::REG_IN_MIN:  in_min         <= pwdata[WIDTH_W-1:0];
        rcpc_pkg::REG_IN_MAX:  in_max         <= pwdata[WIDTH_W-1:0];
        rcpc_pkg::REG_OUT_MIN: out_min        <= pwdata[VAL_W-1:0];
        rcpc_pkg::REG_OUT_MAX: out_max        <= pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      rcpc_pkg::REG_ENABLE:  prdata = 32'(channel_enable);
      rcpc_pkg::REG_IN_MIN:  prdata = 32'(in_min);
      rcpc_pkg::REG_IN_MAX:  prdata = 32'(in_max);
      rcpc_pkg::REG_OUT_MIN: prdata = 32'(out_min);
      rcpc_pkg::REG_OUT_MAX: prdata = 32'(out_max);
      default:               prdata = '0;
    endcase
  end

  // An in-range result always carries the same held and mapped values.
  a_held_matches: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[35:20] == m_tdata[51:36]))
    else $error("held value differs from an in-range mapped value");

  // With an ordered range the mapped value stays inside it.
  a_clamp_bounds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_min <= out_max)) |->
      (($signed(m_tdata[35:20]) >= out_min) && ($signed(m_tdata[35:20]) <= out_max)))
    else $error("mapped value outside the output range");

  // The divider only runs after the multiplier has finished.
  a_unit_order: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (mul_stat.done && !mul_stat.busy))
    else $error("divider started before the product was ready");

  // No result beat is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result beat present after reset");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for rc_pulse_capture_and_range_map.
// Depends on rcpc_pkg and the block's RTL; it predicts each pulse result
// in its own model and checks every result beat against it.
module testbench;

  localparam int CHANNELS    = 10;
  localparam int SETTLE_CYC  = 60;
  localparam int CYCLE_LIMIT = 600000;
  localparam int CHAN_W      = rcpc_pkg::CHAN_W;
  localparam int STAMP_W     = rcpc_pkg::STAMP_W;
  localparam int WIDTH_W     = rcpc_pkg::WIDTH_W;
  localparam int VAL_W       = rcpc_pkg::VAL_W;

  // One expected or observed result beat.
  typedef struct packed {
    logic [CHAN_W-1:0]         chan;
    logic [WIDTH_W-1:0]        width;
    logic signed [VAL_W-1:0]   mapped;
    logic signed [VAL_W-1:0]   held;
    logic                      in_range;
  } pulse_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the registers and the per-channel state.
  logic [CHANNELS-1:0]     enable_reg;
  logic [WIDTH_W-1:0]      in_min_reg;
  logic [WIDTH_W-1:0]      in_max_reg;
  logic signed [VAL_W-1:0] out_min_reg;
  logic signed [VAL_W-1:0] out_max_reg;
  logic [STAMP_W-1:0]      rise_stamp [CHANNELS];
  logic signed [VAL_W-1:0] held_value [CHANNELS];

  pulse_result_t expected_pulses [$];
  pulse_result_t got_pulse;
  pulse_result_t want_pulse;

  int  mismatch_count = 0;
  int  pulses_checked = 0;
  int  items_sent = 0;
  int  live_items = 0;
  int  reg_writes = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  src_steady = 1'b0;
  bit  sink_steady = 1'b0;

  rc_pulse_capture_and_range_map #(
    .CHANNELS(CHANNELS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int draw_gap(bit allow_zero);
    int r;
    r = $urandom_range(0, 99);
    if (allow_zero && r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Pulse width and range mapping of one edge; returns 1 if the channel is live.
  function automatic bit predict_edge(logic [CHAN_W-1:0] ch, logic lvl,
                                      logic [STAMP_W-1:0] stamp);
    logic [STAMP_W-1:0] diff;
    logic [WIDTH_W-1:0] w;
    longint             span;
    longint             raw;
    pulse_result_t      r;
    if (ch >= CHANNELS || !enable_reg[ch]) return 1'b0;
    if (lvl) begin
      rise_stamp[ch] = stamp;
      return 1'b1;
    end
    diff = stamp - rise_stamp[ch];
    w = (diff > 32'd65535) ? 16'hFFFF : diff[WIDTH_W-1:0];
    span = longint'(in_max_reg) - longint'(in_min_reg);
    if (span == 0)
      raw = longint'(out_min_reg);
    else
      raw = (longint'(w) - longint'(in_min_reg)) *
            (longint'(out_max_reg) - longint'(out_min_reg)) / span +
            longint'(out_min_reg);
    r.chan = ch;
    r.width = w;
    // The lower bound wins when the output range is inverted.
    if (raw < longint'(out_min_reg))
      r.mapped = out_min_reg;
    else if (raw > longint'(out_max_reg))
      r.mapped = out_max_reg;
    else
      r.mapped = raw[VAL_W-1:0];
    r.in_range = (raw >= longint'(out_min_reg)) && (raw <= longint'(out_max_reg));
    if (r.in_range) held_value[ch] = raw[VAL_W-1:0];
    r.held = held_value[ch];
    expected_pulses.push_back(r);
    return 1'b1;
  endfunction

  function automatic void report_field(string name, longint want_v, longint got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch on channel %0d, expected %0d, got %0d",
               $time, name, want_pulse.chan, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  // Result checker: each result beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_pulse.chan     = m_tdata[3:0];
      got_pulse.width    = m_tdata[19:4];
      got_pulse.mapped   = m_tdata[35:20];
      got_pulse.held     = m_tdata[51:36];
      got_pulse.in_range = m_tuser;
      if (expected_pulses.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got channel %0d width %0d",
                 $time, got_pulse.chan, got_pulse.width);
        mismatch_count++;
      end else begin
        want_pulse = expected_pulses.pop_front();
        report_field("out_chan", want_pulse.chan, got_pulse.chan);
        report_field("pulse_width", want_pulse.width, got_pulse.width);
        report_field("mapped_value", want_pulse.mapped, got_pulse.mapped);
        report_field("held_value", want_pulse.held, got_pulse.held);
        report_field("in_range", want_pulse.in_range, got_pulse.in_range);
        pulses_checked++;
      end
    end
  end

  // Receiver back-pressure, with stretches of steady readiness.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!sink_steady && $urandom_range(0, 99) < 25) stall_left <= draw_gap(1'b0);
    end
    if ($urandom_range(0, 299) == 0) sink_steady <= !sink_steady;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_pulses.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Send one edge beat, after a random gap, and predict its effect.
  task automatic send_edge(input logic [CHAN_W-1:0] ch, input logic lvl,
                           input logic [STAMP_W-1:0] stamp);
    int gap;
    gap = src_steady ? 0 : draw_gap(1'b1);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, stamp, ch};
    s_tuser <= lvl;
    do @(posedge clk); while (!s_tready);
    if (predict_edge(ch, lvl, stamp)) live_items++;
    items_sent++;
  endtask

  // A rising edge at some time and a falling edge w microseconds later.
  task automatic send_pulse(input logic [CHAN_W-1:0] ch, input logic [STAMP_W-1:0] start,
                            input logic [STAMP_W-1:0] w);
    send_edge(ch, 1'b1, start);
    send_edge(ch, 1'b0, start + w);
  endtask

  // Hold the input until every predicted result has arrived.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_pulses.size() != 0) @(posedge clk);
  endtask

  // Drain and let the last falling edge finish before touching registers.
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      rcpc_pkg::REG_ENABLE:  enable_reg = value[CHANNELS-1:0];
      rcpc_pkg::REG_IN_MIN:  in_min_reg = value[WIDTH_W-1:0];
      rcpc_pkg::REG_IN_MAX:  in_max_reg = value[WIDTH_W-1:0];
      rcpc_pkg::REG_OUT_MIN: out_min_reg = value[VAL_W-1:0];
      rcpc_pkg::REG_OUT_MAX: out_max_reg = value[VAL_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic write_ranges(input int imin, input int imax, input int omin, input int omax);
    write_reg(rcpc_pkg::REG_IN_MIN, 32'(imin));
    write_reg(rcpc_pkg::REG_IN_MAX, 32'(imax));
    write_reg(rcpc_pkg::REG_OUT_MIN, 32'(omin));
    write_reg(rcpc_pkg::REG_OUT_MAX, 32'(omax));
  endtask

  // Random channel, nearly always an enabled one.
  function automatic logic [CHAN_W-1:0] pick_channel();
    logic [CHAN_W-1:0] ch;
    if ($urandom_range(0, 9) == 0) return CHAN_W'($urandom_range(0, 15));
    do ch = CHAN_W'($urandom_range(0, CHANNELS - 1)); while (!enable_reg[ch]);
    return ch;
  endfunction

  // Pulse width mostly around the input range, sometimes far off or saturating.
  function automatic logic [STAMP_W-1:0] pick_width();
    int lo;
    int hi;
    int r;
    lo = (in_min_reg < in_max_reg) ? int'(in_min_reg) : int'(in_max_reg);
    hi = (in_min_reg < in_max_reg) ? int'(in_max_reg) : int'(in_min_reg);
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range((lo > 300) ? lo - 300 : 0, hi + 300);
    if (r < 82) return $urandom_range(0, 65535);
    if (r < 92) return $urandom_range(65536, 200000);
    return $urandom;
  endfunction

  // New register setting for a random phase; writes every register.
  task automatic randomize_config(input int kind);
    int imin;
    int omin;
    if ($urandom_range(0, 9) < 7)
      write_reg(rcpc_pkg::REG_ENABLE, 32'h3FF);
    else
      write_reg(rcpc_pkg::REG_ENABLE,
                32'($urandom_range(0, 1023)) | (32'd1 << $urandom_range(0, 9)));
    case (kind)
      0: begin
        if ($urandom_range(0, 1) == 0) write_ranges(0, 65535, -32768, 32767);
        else write_ranges(65535, 0, 32767, -32768);
      end
      1: write_ranges($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
      2: begin
        imin = $urandom_range(0, 60000);
        write_ranges(imin, imin, int'($urandom_range(0, 2000)) - 1000, 1000);
      end
      default: begin
        imin = $urandom_range(500, 1500);
        omin = int'($urandom_range(0, 2000)) - 1000;
        write_ranges(imin, imin + int'($urandom_range(100, 1500)),
                     omin, omin + int'($urandom_range(1, 3000)));
      end
    endcase
  endtask

  // Edges before any channel is enabled produce nothing.
  task automatic test_reset_disabled();
    send_edge(4'd0, 1'b1, 32'd0);
    send_edge(4'd9, 1'b0, 32'd1500);
  endtask

  // Default ranges: in range, below range, saturation, wraparound, repeated rise, nonexistent channel.
  task automatic test_default_map();
    settle();
    write_reg(rcpc_pkg::REG_ENABLE, 32'h3FF);
    send_edge(4'd3, 1'b0, 32'd1500);
    send_pulse(4'd1, 32'd100, 32'd1000);
    send_pulse(4'd4, 32'd5, 32'd500);
    send_pulse(4'd5, 32'hFFFF_FFFF, 32'd100000);
    send_pulse(4'd6, 32'hFFFF_FFF0, 32'd1999);
    send_edge(4'd7, 1'b1, 32'd0);
    send_pulse(4'd7, 32'd1000, 32'd1250);
    send_edge(4'd15, 1'b1, 32'hFFFF_FFFF);
    send_edge(4'd15, 1'b0, 32'd0);
  endtask

  // Only odd channels enabled.
  task automatic test_channel_mask();
    settle();
    write_reg(rcpc_pkg::REG_ENABLE, 32'h2AA);
    send_pulse(4'd2, 32'd40, 32'd1200);
    send_pulse(4'd3, 32'd40, 32'd1800);
  endtask

  // Zero input span, inverted output range, and full-scale ranges both ways.
  task automatic test_range_corners();
    settle();
    write_reg(rcpc_pkg::REG_ENABLE, 32'h3FF);
    write_ranges(1500, 1500, -20, 20);
    send_pulse(4'd0, 32'd7, 32'd3000);
    settle();
    write_ranges(1000, 2000, 100, -100);
    send_pulse(4'd8, 32'd9, 32'd1500);
    settle();
    write_ranges(0, 65535, -32768, 32767);
    send_pulse(4'd9, 32'h8000_0000, 32'd70000);
    settle();
    write_ranges(65535, 0, -32768, 32767);
    send_pulse(4'd9, 32'h1234_5678, 32'd0);
  endtask

  // Random phases: mostly well-formed pulses, some interleaved, some noise.
  task automatic test_random_traffic();
    int               phase_goal;
    int               pick;
    logic [CHAN_W-1:0] ch_a;
    logic [CHAN_W-1:0] ch_b;
    logic [STAMP_W-1:0] t_a;
    logic [STAMP_W-1:0] t_b;
    for (int phase = 0; phase < 5; phase++) begin
      settle();
      randomize_config((phase == 0) ? 0 : $urandom_range(0, 5));
      src_steady = (phase == 2);
      phase_goal = live_items + 80;
      while (live_items < phase_goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          send_pulse(pick_channel(), $urandom, pick_width());
        end else if (pick < 75) begin
          ch_a = pick_channel();
          ch_b = pick_channel();
          t_a = $urandom;
          t_b = t_a + $urandom_range(0, 500);
          send_edge(ch_a, 1'b1, t_a);
          send_edge(ch_b, 1'b1, t_b);
          send_edge(ch_a, 1'b0, t_a + pick_width());
          send_edge(ch_b, 1'b0, t_b + pick_width());
        end else if (pick < 96) begin
          send_edge(CHAN_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), $urandom);
        end else begin
          drain_results();
        end
      end
    end
    src_steady = 1'b0;
  endtask

  initial begin
    enable_reg = '0;
    in_min_reg = rcpc_pkg::IN_MIN_RST;
    in_max_reg = rcpc_pkg::IN_MAX_RST;
    out_min_reg = rcpc_pkg::OUT_MIN_RST;
    out_max_reg = rcpc_pkg::OUT_MAX_RST;
    for (int i = 0; i < CHANNELS; i++) begin
      rise_stamp[i] = '0;
      held_value[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_disabled();
    test_default_map();
    test_channel_mask();
    test_range_corners();
    test_random_traffic();

    settle();
    $display("Covered %0d edge beats (%0d on enabled channels) and %0d result beats",
             items_sent, live_items, pulses_checked);
    $display("across %0d register writes, including zero-span, inverted and full-scale ranges.",
             reg_writes);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
